>>> rtl/bas_pkg.sv
`default_nettype none

package bas_pkg;

    // Field and datapath widths.
    localparam int ADDR_W = 24;
    localparam int LIM_W  = 25;
    localparam int WORD_W = 32;
    localparam int ALU_W  = 34;

    // Defaults for the top-level parameters.
    localparam int SLOTS_DEF        = 16;
    localparam int HEADER_BYTES_DEF = 16;

    // Request codes.
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_RESIZE  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BLOCK_BASE    = 2'd0;
    localparam logic [1:0] CFG_MEMORY_SIZE   = 2'd1;
    localparam logic [1:0] CFG_HEAP_START    = 2'd2;
    localparam logic [1:0] CFG_INITIAL_LIMIT = 2'd3;

    // Reply words and limits.
    localparam logic [WORD_W-1:0] ERR_SPACE = 32'h8100_0000;
    localparam logic [WORD_W-1:0] ERR_SLOTS = 32'h8200_0000;
    localparam logic [WORD_W-1:0] ERR_MISS  = 32'hFFFF_FFF9;
    localparam logic [WORD_W-1:0] QUERY_MIN = 32'h0100_0000;
    localparam logic [LIM_W-1:0]  CAP_LIMIT = 25'h100_0000;
    localparam logic [LIM_W-1:0]  MEM_SIZE_RST = 25'h010_0000;

    // Header word offsets written by a resize.
    localparam logic [7:0] RSZ_LIMIT_OFF = 8'h08;
    localparam logic [7:0] RSZ_COPY_OFF  = 8'h38;

    // Operation presented to the shared adder.
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

endpackage

`default_nettype wire

>>> rtl/bas_if.sv
`default_nettype none

// Request channel: one beat carries one allocator request.
interface bas_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  op;
    logic [bas_pkg::WORD_W-1:0]  size;
    logic [bas_pkg::WORD_W-1:0]  addr;

    modport source (output valid, op, size, addr, input ready);
    modport sink   (input valid, op, size, addr, output ready);
endinterface

// Response channel: one beat carries a header write or the final reply.
interface bas_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [bas_pkg::ADDR_W-1:0]  mem_addr;
    logic [bas_pkg::WORD_W-1:0]  mem_data;
    logic [bas_pkg::WORD_W-1:0]  reply;
    logic [bas_pkg::LIM_W-1:0]   new_limit;
    logic                        last;

    modport source (output valid, kind, mem_addr, mem_data, reply, new_limit, last,
                    input ready);
    modport sink   (input valid, kind, mem_addr, mem_data, reply, new_limit, last,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/bump_allocator_with_slot_table.sv
`default_nettype none

// Bump allocator with a slot table. Requests arrive one beat at a time on req and are
// worked through by a small sequencer around one shared adder, so req is ready only when
// the block is idle. A space query ends in one reply beat; a normal allocate examines
// slots one at a time (up to SLOTS), then gives four header write beats and a reply beat;
// a release examines slots one at a time, each slot base coming from the slot memory
// through a registered read, then gives a reply beat; a normal resize gives two header
// write beats and a reply beat. Each beat holds the sequencer for as long as rsp stalls.
// Results leave through an output register, so the next request is accepted while the
// last beat still waits on rsp. Slot occupancy is kept in flip-flops cleared by reset,
// so no clearing pass follows reset.
module bump_allocator_with_slot_table
#(
    parameter int SLOTS        = bas_pkg::SLOTS_DEF,
    parameter int HEADER_BYTES = bas_pkg::HEADER_BYTES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [bas_pkg::LIM_W-1:0]  cfg_data,
    bas_req_if.sink                    req,
    bas_rsp_if.source                  rsp
);

    localparam int AW    = bas_pkg::ALU_W;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [20:0] {
        S_IDLE    = 21'h000001,
        S_FREE_T  = 21'h000002,
        S_FREE_D  = 21'h000004,
        S_A_SCAN  = 21'h000008,
        S_A_BASE  = 21'h000010,
        S_A_TOT   = 21'h000020,
        S_A_END   = 21'h000040,
        S_A_CHK   = 21'h000080,
        S_A_HP    = 21'h000100,
        S_A_WR    = 21'h000200,
        S_A_RET   = 21'h000400,
        S_R_KEY   = 21'h000800,
        S_R_RD    = 21'h001000,
        S_R_CMP   = 21'h002000,
        S_Z_ADDR  = 21'h004000,
        S_Z_TOT   = 21'h008000,
        S_Z_CHK   = 21'h010000,
        S_Z_AVAIL = 21'h020000,
        S_Z_HP    = 21'h040000,
        S_Z_WR    = 21'h080000,
        S_REPLY   = 21'h100000
    } state_t;

    // Control state.
    state_t                       state_reg, state_next;
    logic [IDX_W-1:0]             scan_idx_reg, scan_idx_next;
    logic [1:0]                   wr_cnt_reg, wr_cnt_next;
    logic [SLOTS-1:0]             slot_valid_reg, slot_valid_next;
    logic [bas_pkg::LIM_W-1:0]    hp_reg, hp_next;
    logic [bas_pkg::LIM_W-1:0]    bl_reg, bl_next;
    logic [bas_pkg::ADDR_W-1:0]   block_base_reg, block_base_next;
    logic [bas_pkg::LIM_W-1:0]    memory_size_reg, memory_size_next;
    logic                         out_valid_reg, out_valid_next;

    // Request and working registers.
    logic [bas_pkg::WORD_W-1:0]   size_reg, size_next;
    logic [bas_pkg::WORD_W-1:0]   addr_reg, addr_next;
    logic [25:0]                  base_reg, base_next;
    logic [32:0]                  tot_reg, tot_next;
    logic [26:0]                  sum_reg, sum_next;
    logic [bas_pkg::LIM_W-1:0]    free_reg, free_next;
    logic                         key_bad_reg, key_bad_next;
    logic [bas_pkg::WORD_W-1:0]   reply_val_reg, reply_val_next;
    logic [bas_pkg::LIM_W-1:0]    nl_val_reg, nl_val_next;
    logic [IDX_W-1:0]             slot_reg, slot_next;

    // Output register.
    logic                         out_kind_reg, out_kind_next;
    logic [bas_pkg::ADDR_W-1:0]   out_mem_addr_reg, out_mem_addr_next;
    logic [bas_pkg::WORD_W-1:0]   out_mem_data_reg, out_mem_data_next;
    logic [bas_pkg::WORD_W-1:0]   out_reply_reg, out_reply_next;
    logic [bas_pkg::LIM_W-1:0]    out_nl_reg, out_nl_next;
    logic                         out_last_reg, out_last_next;

    // Slot memory.
    logic [bas_pkg::ADDR_W-1:0]   slot_mem [SLOTS];
    logic [bas_pkg::ADDR_W-1:0]   rd_reg;
    logic                         slot_we;

    bas_pkg::alu_req_t            alu_req;
    logic [AW-1:0]                alu_res;
    logic                         alu_neg;
    logic                         out_free;
    logic [bas_pkg::LIM_W-1:0]    cap;

    bas_alu u_alu
    (
        .req (alu_req),
        .res (alu_res)
    );

    assign alu_neg   = alu_res[AW-1];
    assign out_free  = !out_valid_reg || rsp.ready;
    assign cap       = bl_reg[bas_pkg::LIM_W-1] ? bas_pkg::CAP_LIMIT : bl_reg;
    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid     = out_valid_reg;
    assign rsp.kind      = out_kind_reg;
    assign rsp.mem_addr  = out_mem_addr_reg;
    assign rsp.mem_data  = out_mem_data_reg;
    assign rsp.reply     = out_reply_reg;
    assign rsp.new_limit = out_nl_reg;
    assign rsp.last      = out_last_reg;

    // Sequencer: each arithmetic step drives the shared adder once and keeps what it needs.
    always_comb
    begin
        state_next        = state_reg;
        scan_idx_next     = scan_idx_reg;
        wr_cnt_next       = wr_cnt_reg;
        slot_valid_next   = slot_valid_reg;
        hp_next           = hp_reg;
        bl_next           = bl_reg;
        block_base_next   = block_base_reg;
        memory_size_next  = memory_size_reg;
        out_valid_next    = out_valid_reg;
        size_next         = size_reg;
        addr_next         = addr_reg;
        base_next         = base_reg;
        tot_next          = tot_reg;
        sum_next          = sum_reg;
        free_next         = free_reg;
        key_bad_next      = key_bad_reg;
        reply_val_next    = reply_val_reg;
        nl_val_next       = nl_val_reg;
        slot_next         = slot_reg;
        out_kind_next     = out_kind_reg;
        out_mem_addr_next = out_mem_addr_reg;
        out_mem_data_next = out_mem_data_reg;
        out_reply_next    = out_reply_reg;
        out_nl_next       = out_nl_reg;
        out_last_next     = out_last_reg;
        slot_we           = 1'b0;
        alu_req           = '0;

        // The downstream side takes the waiting beat.
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    size_next = req.size;
                    addr_next = req.addr;
                    unique case (req.op)
                        bas_pkg::OP_ALLOC:   state_next = S_FREE_T;
                        bas_pkg::OP_RELEASE: state_next = S_R_KEY;
                        bas_pkg::OP_RESIZE:  state_next = S_Z_ADDR;
                        default:             state_next = S_IDLE;
                    endcase
                end
            end

            // Free bytes: block_limit - (heap_pointer + header), floored at zero.
            S_FREE_T:
            begin
                alu_req.a  = AW'(hp_reg);
                alu_req.b  = AW'(HEADER_BYTES);
                sum_next   = alu_res[26:0];
                state_next = S_FREE_D;
            end

            S_FREE_D:
            begin
                alu_req.a   = AW'(bl_reg);
                alu_req.b   = AW'(sum_reg);
                alu_req.sub = 1'b1;
                free_next   = alu_neg ? '0 : alu_res[bas_pkg::LIM_W-1:0];
                if (size_reg >= bas_pkg::QUERY_MIN)
                begin
                    reply_val_next = {7'b0, (alu_neg ? 25'd0 : alu_res[bas_pkg::LIM_W-1:0])};
                    nl_val_next    = '0;
                    state_next     = S_REPLY;
                end
                else
                begin
                    scan_idx_next = '0;
                    state_next    = S_A_SCAN;
                end
            end

            // First empty slot, one slot a cycle.
            S_A_SCAN:
            begin
                if (!slot_valid_reg[scan_idx_reg])
                begin
                    slot_next  = scan_idx_reg;
                    state_next = S_A_BASE;
                end
                else if (scan_idx_reg == LAST_IDX)
                begin
                    reply_val_next = bas_pkg::ERR_SLOTS;
                    nl_val_next    = '0;
                    state_next     = S_REPLY;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            // Block base is the heap pointer rounded up to a word.
            S_A_BASE:
            begin
                alu_req.a  = AW'(hp_reg);
                alu_req.b  = AW'(2'd3);
                base_next  = {alu_res[25:2], 2'b00};
                state_next = S_A_TOT;
            end

            S_A_TOT:
            begin
                alu_req.a  = AW'(HEADER_BYTES);
                alu_req.b  = AW'(size_reg);
                tot_next   = alu_res[32:0];
                state_next = S_A_END;
            end

            S_A_END:
            begin
                alu_req.a  = AW'(base_reg);
                alu_req.b  = AW'(tot_reg);
                sum_next   = alu_res[26:0];
                state_next = S_A_CHK;
            end

            // The block must end at or below the capped block end.
            S_A_CHK:
            begin
                alu_req.a   = AW'(cap);
                alu_req.b   = AW'(sum_reg);
                alu_req.sub = 1'b1;
                if (alu_neg)
                begin
                    reply_val_next = bas_pkg::ERR_SPACE | {8'b0, free_reg[23:0]};
                    nl_val_next    = '0;
                    state_next     = S_REPLY;
                end
                else
                begin
                    slot_we                   = 1'b1;
                    slot_valid_next[slot_reg] = 1'b1;
                    state_next                = S_A_HP;
                end
            end

            S_A_HP:
            begin
                alu_req.a   = AW'(sum_reg);
                alu_req.b   = AW'(2'd3);
                hp_next     = {alu_res[bas_pkg::LIM_W-1:2], 2'b00};
                wr_cnt_next = '0;
                state_next  = S_A_WR;
            end

            // Four header words at base, base+4, base+8 and base+12.
            S_A_WR:
            begin
                alu_req.a = AW'(base_reg);
                alu_req.b = AW'({wr_cnt_reg, 2'b00});
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_kind_next     = 1'b0;
                    out_mem_addr_next = alu_res[bas_pkg::ADDR_W-1:0];
                    out_reply_next    = '0;
                    out_nl_next       = '0;
                    out_last_next     = 1'b0;
                    case (wr_cnt_reg)
                        2'd1:    out_mem_data_next = {6'b0, base_reg};
                        2'd2:    out_mem_data_next = {5'b0, sum_reg};
                        default: out_mem_data_next = '0;
                    endcase
                    wr_cnt_next = wr_cnt_reg + 1'b1;
                    if (wr_cnt_reg == 2'd3)
                    begin
                        state_next = S_A_RET;
                    end
                end
            end

            S_A_RET:
            begin
                alu_req.a      = AW'(base_reg);
                alu_req.b      = AW'(HEADER_BYTES);
                reply_val_next = alu_res[bas_pkg::WORD_W-1:0];
                nl_val_next    = '0;
                state_next     = S_REPLY;
            end

            // Release: the slot base to match is addr - header.
            S_R_KEY:
            begin
                alu_req.a     = AW'(addr_reg);
                alu_req.b     = AW'(HEADER_BYTES);
                alu_req.sub   = 1'b1;
                key_bad_next  = alu_neg;
                tot_next      = {1'b0, alu_res[bas_pkg::WORD_W-1:0]};
                scan_idx_next = '0;
                state_next    = S_R_RD;
            end

            S_R_RD:
            begin
                state_next = S_R_CMP;
            end

            S_R_CMP:
            begin
                if (slot_valid_reg[scan_idx_reg] && !key_bad_reg
                    && (tot_reg[bas_pkg::WORD_W-1:0] == {8'b0, rd_reg}))
                begin
                    slot_valid_next[scan_idx_reg] = 1'b0;
                    reply_val_next                = '0;
                    nl_val_next                   = '0;
                    state_next                    = S_REPLY;
                end
                else if (scan_idx_reg == LAST_IDX)
                begin
                    reply_val_next = bas_pkg::ERR_MISS;
                    nl_val_next    = '0;
                    state_next     = S_REPLY;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                    state_next    = S_R_RD;
                end
            end

            // Resize: the address must point just past the process block header.
            S_Z_ADDR:
            begin
                alu_req.a = AW'(block_base_reg);
                alu_req.b = AW'(HEADER_BYTES);
                if (AW'(addr_reg) != alu_res)
                begin
                    reply_val_next = bas_pkg::ERR_MISS;
                    nl_val_next    = '0;
                    state_next     = S_REPLY;
                end
                else
                begin
                    state_next = S_Z_TOT;
                end
            end

            S_Z_TOT:
            begin
                alu_req.a  = AW'(HEADER_BYTES);
                alu_req.b  = AW'(size_reg);
                tot_next   = alu_res[32:0];
                state_next = S_Z_CHK;
            end

            S_Z_CHK:
            begin
                alu_req.a   = AW'(memory_size_reg);
                alu_req.b   = AW'(tot_reg);
                alu_req.sub = 1'b1;
                if (alu_neg)
                begin
                    state_next = S_Z_AVAIL;
                end
                else
                begin
                    bl_next    = tot_reg[bas_pkg::LIM_W-1:0];
                    state_next = S_Z_HP;
                end
            end

            // Too large: report what the memory could hold beyond the header.
            S_Z_AVAIL:
            begin
                alu_req.a      = AW'(memory_size_reg);
                alu_req.b      = AW'(HEADER_BYTES);
                alu_req.sub    = 1'b1;
                reply_val_next = bas_pkg::ERR_SPACE
                                 | {8'b0, (alu_neg ? 24'd0 : alu_res[23:0])};
                nl_val_next    = '0;
                state_next     = S_REPLY;
            end

            // Clamp the heap pointer to the new block end.
            S_Z_HP:
            begin
                alu_req.a   = AW'(bl_reg);
                alu_req.b   = AW'(hp_reg);
                alu_req.sub = 1'b1;
                if (alu_neg)
                begin
                    hp_next = bl_reg;
                end
                wr_cnt_next = '0;
                state_next  = S_Z_WR;
            end

            S_Z_WR:
            begin
                alu_req.a = AW'(block_base_reg);
                alu_req.b = wr_cnt_reg[0] ? AW'(bas_pkg::RSZ_COPY_OFF)
                                          : AW'(bas_pkg::RSZ_LIMIT_OFF);
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_kind_next     = 1'b0;
                    out_mem_addr_next = alu_res[bas_pkg::ADDR_W-1:0];
                    out_mem_data_next = {7'b0, bl_reg};
                    out_reply_next    = '0;
                    out_nl_next       = '0;
                    out_last_next     = 1'b0;
                    wr_cnt_next       = wr_cnt_reg + 1'b1;
                    if (wr_cnt_reg == 2'd1)
                    begin
                        reply_val_next = '0;
                        nl_val_next    = bl_reg;
                        state_next     = S_REPLY;
                    end
                end
            end

            // Final reply beat.
            S_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_kind_next     = 1'b1;
                    out_mem_addr_next = '0;
                    out_mem_data_next = '0;
                    out_reply_next    = reply_val_reg;
                    out_nl_next       = nl_val_reg;
                    out_last_next     = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Configuration writes; heap_start and initial_limit load the live state.
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                bas_pkg::CFG_BLOCK_BASE:    block_base_next  = cfg_data[bas_pkg::ADDR_W-1:0];
                bas_pkg::CFG_MEMORY_SIZE:   memory_size_next = cfg_data;
                bas_pkg::CFG_HEAP_START:    hp_next          = cfg_data;
                bas_pkg::CFG_INITIAL_LIMIT: bl_next          = cfg_data;
                default:                    block_base_next  = block_base_reg;
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            scan_idx_reg    <= '0;
            wr_cnt_reg      <= '0;
            slot_valid_reg  <= '0;
            hp_reg          <= '0;
            bl_reg          <= '0;
            block_base_reg  <= '0;
            memory_size_reg <= bas_pkg::MEM_SIZE_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            scan_idx_reg    <= scan_idx_next;
            wr_cnt_reg      <= wr_cnt_next;
            slot_valid_reg  <= slot_valid_next;
            hp_reg          <= hp_next;
            bl_reg          <= bl_next;
            block_base_reg  <= block_base_next;
            memory_size_reg <= memory_size_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        size_reg         <= size_next;
        addr_reg         <= addr_next;
        base_reg         <= base_next;
        tot_reg          <= tot_next;
        sum_reg          <= sum_next;
        free_reg         <= free_next;
        key_bad_reg      <= key_bad_next;
        reply_val_reg    <= reply_val_next;
        nl_val_reg       <= nl_val_next;
        slot_reg         <= slot_next;
        out_kind_reg     <= out_kind_next;
        out_mem_addr_reg <= out_mem_addr_next;
        out_mem_data_reg <= out_mem_data_next;
        out_reply_reg    <= out_reply_next;
        out_nl_reg       <= out_nl_next;
        out_last_reg     <= out_last_next;
    end

    // Slot base memory: one write port, one registered read at the scan index.
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_reg] <= base_reg[bas_pkg::ADDR_W-1:0];
        end
        rd_reg <= slot_mem[scan_idx_reg];
    end

endmodule

`default_nettype wire

>>> rtl/bas_alu.sv
`default_nettype none

// Shared adder/subtractor used by the arithmetic steps of the sequencer.
module bas_alu
(
    input  var bas_pkg::alu_req_t         req,
    output logic [bas_pkg::ALU_W-1:0]     res
);

    // Operands are well below the top bit, so the top bit of a difference is its sign.
    always_comb
    begin
        if (req.sub)
        begin
            res = req.a - req.b;
        end
        else
        begin
            res = req.a + req.b;
        end
    end

endmodule

`default_nettype wire
